// ----- design/clustered_transposition_table_macros.svh -----
// Assertion macros shared by the transposition table modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH
`define CLUSTERED_TRANSPOSITION_TABLE_MACROS_SVH

// Same-cycle implication.
`define CTT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ctt_pkg.sv -----
// Shared types and sizes for the clustered transposition table.
// No dependencies; imported by the front, back and top level.
package ctt_pkg;

	// Set count is a power of two: the set index is the low hash bits.
	localparam int SET_W   = 12;
	localparam int SETS    = 1 << SET_W;
	localparam int WAYS    = 4;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MODE_W  = 2;
	localparam int HASH_W  = 64;
	localparam int KEY_W   = 64;
	localparam int SCORE_W = 16;
	localparam int DEPTH_W = 8;
	localparam int FLAG_W  = 2;
	localparam int OUT_W   = 3;

	// Operation class decided by the front
	typedef enum logic [1:0] {
		OP_PROBE = 2'd0,
		OP_STORE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [OUT_W-1:0] {
		OUT_MISS     = 3'd0,
		OUT_HIT      = 3'd1,
		OUT_UPDATED  = 3'd2,
		OUT_KEPT     = 3'd3,
		OUT_FILLED   = 3'd4,
		OUT_REPLACED = 3'd5,
		OUT_CLEARED  = 3'd6
	} outcome_t;

	typedef struct packed {
		op_t                       op;
		logic [HASH_W-1:0]         hash;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [FLAG_W-1:0]         flag;
	} item_t;

	// Queue head towards the back
	typedef struct packed {
		logic  valid;
		item_t item;
	} fb_t;

	// Back status towards the front
	typedef struct packed {
		logic pop;
		logic init;
	} bf_t;

	typedef struct packed {
		logic [HASH_W-1:0]         hash;
		logic [KEY_W-1:0]          key;
		logic signed [SCORE_W-1:0] score;
		logic [DEPTH_W-1:0]        depth;
		logic [FLAG_W-1:0]         flag;
	} slot_t;

	typedef slot_t [WAYS-1:0] row_t;

endpackage

// ----- design/ctt_front.sv -----
// Front of the transposition table: takes command beats, classifies the
// mode and holds them in a two-entry queue for the back. Uses ctt_pkg.
`include "clustered_transposition_table_macros.svh"

module ctt_front import ctt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [MODE_W-1:0]         mode,
	input  logic [HASH_W-1:0]         lookup_hash,
	input  logic [KEY_W-1:0]          board_key,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [DEPTH_W-1:0]        new_depth,
	input  logic [FLAG_W-1:0]         new_flag,
	output fb_t                       fb,
	input  bf_t                       bf
);

	typedef enum logic [MODE_W-1:0] {
		MODE_PROBE = 2'd0,
		MODE_STORE = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	item_t      in_item;
	item_t      q_mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       full;
	logic       push;

	// Classify the incoming beat; the spare mode code becomes a no-op
	always_comb begin
		in_item.hash  = lookup_hash;
		in_item.key   = board_key;
		in_item.score = new_score;
		in_item.depth = new_depth;
		in_item.flag  = new_flag;
		unique case (mode)
			MODE_PROBE: in_item.op = OP_PROBE;
			MODE_STORE: in_item.op = OP_STORE;
			MODE_CLEAR: in_item.op = OP_CLEAR;
			default:    in_item.op = OP_NOP;
		endcase
	end

	// Handshake: no beats while full or while the table is being wiped after reset
	assign full = (count_q == 2'd2);
	assign busy = full || bf.init;
	assign push = start && !busy;

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (bf.pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, bf.pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= in_item;
	end

	assign fb.valid = (count_q != 2'd0);
	assign fb.item  = q_mem[rd_ptr_q];

	`CTT_ASSERT_IMPLY(a_no_pop_when_empty, bf.pop, count_q != 2'd0, "pop from empty queue")
	`CTT_ASSERT_IMPLY(a_count_in_range, 1'b1, count_q != 2'd3, "queue count overflow")
	`CTT_ASSERT_NEXT(a_count_holds, !push && !bf.pop, $stable(count_q), "queue count drifted")

endmodule

// ----- design/ctt_back.sv -----
// Back of the transposition table: set memory, probe/store engine and the
// wipe sequencer for reset and clear. Uses ctt_pkg.
`include "clustered_transposition_table_macros.svh"

module ctt_back import ctt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fb_t                        fb,
	output bf_t                        bf,
	output logic                       done,
	output outcome_t                   outcome,
	output logic signed [SCORE_W-1:0]  found_score,
	output logic [DEPTH_W-1:0]         found_depth,
	output logic [FLAG_W-1:0]          found_flag
);

	typedef enum logic [3:0] {
		ST_INIT  = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_CLEAR = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [SET_W-1:0]          cnt_q;
	item_t                     item_q;
	row_t                      row_q;
	row_t                      mem [SETS];
	logic                      done_q;
	outcome_t                  outcome_q;
	logic signed [SCORE_W-1:0] fs_q;
	logic [DEPTH_W-1:0]        fd_q;
	logic [FLAG_W-1:0]         ff_q;

	logic             pop;
	logic             wipe;
	logic             last;
	logic [SET_W-1:0] rd_addr;
	logic [SET_W-1:0] wr_addr;
	logic             wr_en;
	row_t             wr_row;

	logic                      ex_write;
	logic [WAY_W-1:0]          ex_way;
	outcome_t                  ex_outcome;
	logic signed [SCORE_W-1:0] ex_fs;
	logic [DEPTH_W-1:0]        ex_fd;
	logic [FLAG_W-1:0]         ex_ff;
	slot_t                     new_slot;

	assign pop     = (state_q == ST_IDLE) && fb.valid;
	assign wipe    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign last    = (cnt_q == {SET_W{1'b1}});
	assign rd_addr = fb.item.hash[SET_W-1:0];
	assign bf.pop  = pop;
	assign bf.init = (state_q == ST_INIT);

	// Set memory: one row write, one registered row read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_row;
		row_q <= mem[rd_addr];
	end

	// Way search over the set read back
	always_comb begin
		logic             any_hit;
		logic             any_empty;
		logic [WAY_W-1:0] hit_w;
		logic [WAY_W-1:0] empty_w;
		logic [WAY_W-1:0] vic_w;
		any_hit   = 1'b0;
		any_empty = 1'b0;
		hit_w     = '0;
		empty_w   = '0;
		vic_w     = '0;
		// downward scan leaves the lowest way
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_q[w].hash == item_q.hash && row_q[w].key == item_q.key) begin
				any_hit = 1'b1;
				hit_w   = WAY_W'(w);
			end
			if (row_q[w].hash == '0) begin
				any_empty = 1'b1;
				empty_w   = WAY_W'(w);
			end
		end
		// least depth, ties to the lowest way
		for (int w = 1; w < WAYS; w++) begin
			if (row_q[w].depth < row_q[vic_w].depth)
				vic_w = WAY_W'(w);
		end

		new_slot = '{hash: item_q.hash, key: item_q.key, score: item_q.score,
			depth: item_q.depth, flag: item_q.flag};
		ex_write   = 1'b0;
		ex_way     = '0;
		ex_outcome = OUT_MISS;
		ex_fs      = '0;
		ex_fd      = '0;
		ex_ff      = '0;
		unique case (item_q.op)
			OP_PROBE: begin
				if (any_hit) begin
					ex_outcome = OUT_HIT;
					ex_fs      = row_q[hit_w].score;
					ex_fd      = row_q[hit_w].depth;
					ex_ff      = row_q[hit_w].flag;
				end
			end
			OP_STORE: begin
				priority if (any_hit) begin
					ex_way = hit_w;
					if (item_q.depth > row_q[hit_w].depth) begin
						ex_write   = 1'b1;
						ex_outcome = OUT_UPDATED;
					end else begin
						ex_outcome = OUT_KEPT;
					end
				end else if (any_empty) begin
					ex_write   = 1'b1;
					ex_way     = empty_w;
					ex_outcome = OUT_FILLED;
				end else begin
					ex_write   = 1'b1;
					ex_way     = vic_w;
					ex_outcome = OUT_REPLACED;
				end
			end
			OP_CLEAR: ex_outcome = OUT_CLEARED;
			OP_NOP:   ex_outcome = OUT_MISS;
			default:  ex_outcome = OUT_MISS;
		endcase
	end

	// Write-back row: patched set, or zeros while wiping
	always_comb begin
		wr_row         = row_q;
		wr_row[ex_way] = new_slot;
		if (wipe)
			wr_row = '0;
	end
	assign wr_en   = wipe || ((state_q == ST_EXEC) && ex_write);
	assign wr_addr = wipe ? cnt_q : item_q.hash[SET_W-1:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (fb.valid) begin
						cnt_q <= '0;
						if (fb.item.op == OP_CLEAR)
							state_q <= ST_CLEAR;
						else
							state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_INIT;
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		if (pop)
			item_q <= fb.item;
		if (state_q == ST_EXEC) begin
			outcome_q <= ex_outcome;
			fs_q      <= ex_fs;
			fd_q      <= ex_fd;
			ff_q      <= ex_ff;
		end else if (state_q == ST_CLEAR && last) begin
			outcome_q <= OUT_CLEARED;
			fs_q      <= '0;
			fd_q      <= '0;
			ff_q      <= '0;
		end
	end

	assign done        = done_q;
	assign outcome     = outcome_q;
	assign found_score = fs_q;
	assign found_depth = fd_q;
	assign found_flag  = ff_q;

	`CTT_ASSERT_IMPLY(a_no_result_in_init, state_q == ST_INIT, !done_q, "result during reset wipe")
	`CTT_ASSERT_NEXT(a_exec_gives_result, state_q == ST_EXEC, done_q, "executed item gave no result")
	`CTT_ASSERT_IMPLY(a_result_source, done_q, $past(state_q == ST_EXEC) || $past(state_q == ST_CLEAR), "result without work")

endmodule

// ----- design/clustered_transposition_table.sv -----
// Clustered transposition table: 4096 sets of 4 slots, probe/store/clear.
// Channels: a command beat (mode, lookup_hash, board_key, new_score,
// new_depth, new_flag) is taken at a clock edge where start is high and
// busy is low. Each command yields one result beat (outcome, found_score,
// found_depth, found_flag), valid for exactly one cycle while done is high;
// the receiver cannot stall, so results must be taken as they come.
// An accepted probe or store waits in the queue while the back is busy,
// is popped into the item register as its set row is read, and is
// resolved in the execute state, which registers the result and raises
// done. The back takes one item at a time: it reads a set row, may write
// the patched row back, and only then pops the next. A clear writes one
// set per cycle, zeroing all SETS = 4096 sets before its result.
// Commands queue two deep ahead of the back; busy rises when the queue is
// full. After reset all 4096 sets are wiped with busy high; the table then
// reads as all zero slots. Depends on ctt_pkg, ctt_front and ctt_back.
module clustered_transposition_table import ctt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [MODE_W-1:0]         mode,
	input  logic [HASH_W-1:0]         lookup_hash,
	input  logic [KEY_W-1:0]          board_key,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [DEPTH_W-1:0]        new_depth,
	input  logic [FLAG_W-1:0]         new_flag,
	output logic                      done,
	output logic [OUT_W-1:0]          outcome,
	output logic signed [SCORE_W-1:0] found_score,
	output logic [DEPTH_W-1:0]        found_depth,
	output logic [FLAG_W-1:0]         found_flag
);

	fb_t      fb;
	bf_t      bf;
	outcome_t outcome_e;

	// Command intake and queue
	ctt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.lookup_hash (lookup_hash),
		.board_key   (board_key),
		.new_score   (new_score),
		.new_depth   (new_depth),
		.new_flag    (new_flag),
		.fb          (fb),
		.bf          (bf)
	);

	// Table memory and execution
	ctt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fb          (fb),
		.bf          (bf),
		.done        (done),
		.outcome     (outcome_e),
		.found_score (found_score),
		.found_depth (found_depth),
		.found_flag  (found_flag)
	);

	assign outcome = outcome_e;

endmodule
